[hw/rtl/thg_pkg.sv]
// Package for the thermal hysteresis governor.
// Holds reset values, field widths, codes and the shared control types.
// No dependencies.
package thg_pkg;

  localparam int AVG_DEPTH_DEF = 4;
  localparam int NUM_STATES    = 4;

  localparam int TEMP_W  = 8;
  localparam int STATE_W = 2;
  localparam int TRIP_W  = 16;
  localparam int CFG_W   = 8;
  localparam int CFG_A_W = 2;
  localparam int BIT_W   = 3;

  localparam logic [TEMP_W-1:0]  RISE_RST     = 8'd75;
  localparam logic [TEMP_W-1:0]  FALL_RST     = 8'd60;
  localparam logic [TEMP_W-1:0]  CRIT_RST     = 8'd95;
  localparam logic [TEMP_W-1:0]  MAXT_RST     = 8'd125;
  localparam logic [TEMP_W-1:0]  AVG_RST      = 8'd45;
  localparam logic [TRIP_W-1:0]  TRIP_MAX     = 16'hFFFF;
  localparam logic [STATE_W-1:0] STATE_MAX    = STATE_W'(NUM_STATES - 1);
  localparam logic [BIT_W-1:0]   DIV_TOP_BIT  = 3'd7;

  localparam logic [CFG_A_W-1:0] CFG_RISE = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_FALL = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_CRIT = 2'd2;
  localparam logic [CFG_A_W-1:0] CFG_MAXT = 2'd3;

  typedef enum logic [1:0] {
    KIND_FORCE,
    KIND_REJECT,
    KIND_SAMPLE
  } item_kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACCUM,
    S_DIV,
    S_FINISH
  } seq_state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic ring_wr;
    logic acc_clr;
    logic acc_add;
    logic div_step;
  } thg_ctrl_t;

endpackage

[hw/rtl/thg_alu.sv]
// Shared add/subtract unit of the governor datapath.
// Used for ring accumulation and for the restoring divide steps; uses thg_pkg.
module thg_alu import thg_pkg::*; #(
  parameter int W = 12
) (
  input  alu_op_t      op_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] res_o,
  output logic         borrow_o
);

  logic [W:0] full;

  always_comb begin
    if (op_i == ALU_SUB) begin
      full = {1'b0, a_i} - {1'b0, b_i};
    end else begin
      full = {1'b0, a_i} + {1'b0, b_i};
    end
  end

  assign res_o    = full[W-1:0];
  assign borrow_o = (op_i == ALU_SUB) && full[W];

endmodule

[hw/rtl/thg_dp.sv]
// Datapath: sample ring, write pointer, fill count, accumulator and quotient.
// Uses thg_pkg and the shared thg_alu.
module thg_dp import thg_pkg::*; #(
  parameter int  AVG_DEPTH = AVG_DEPTH_DEF,
  localparam int FILL_W    = $clog2(AVG_DEPTH + 1),
  localparam int IDX_W     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1,
  localparam int ALU_W     = TEMP_W + FILL_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  thg_ctrl_t         ctrl_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  logic [BIT_W-1:0]  bit_i,
  input  logic [TEMP_W-1:0] temp_i,
  output logic [FILL_W-1:0] fill_o,
  output logic [TEMP_W-1:0] quot_o
);

  logic [TEMP_W-1:0] ring_r [AVG_DEPTH];
  logic [IDX_W-1:0]  wp_r, wp_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [ALU_W-1:0]  acc_r, acc_nxt;
  logic [TEMP_W-1:0] quot_r, quot_nxt;
  logic [ALU_W-1:0]  alu_b;
  logic [ALU_W-1:0]  alu_res;
  logic              alu_borrow;
  alu_op_t           alu_op;

  always_ff @(posedge clk) begin
    if (ctrl_i.ring_wr) begin
      ring_r[wp_r] <= temp_i;
    end
  end

  always_comb begin
    wp_nxt   = wp_r;
    fill_nxt = fill_r;
    if (ctrl_i.ring_wr) begin
      wp_nxt = (wp_r == IDX_W'(AVG_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (fill_r != FILL_W'(AVG_DEPTH)) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_comb begin
    alu_op = ctrl_i.div_step ? ALU_SUB : ALU_ADD;
    if (ctrl_i.div_step) begin
      alu_b = ALU_W'(fill_r) << bit_i;
    end else begin
      alu_b = ALU_W'(ring_r[idx_i]);
    end
  end

  thg_alu #(.W(ALU_W)) u_alu (
    .op_i     (alu_op),
    .a_i      (acc_r),
    .b_i      (alu_b),
    .res_o    (alu_res),
    .borrow_o (alu_borrow)
  );

  always_comb begin
    acc_nxt  = acc_r;
    quot_nxt = quot_r;
    if (ctrl_i.acc_clr) begin
      acc_nxt = '0;
    end else if (ctrl_i.acc_add) begin
      acc_nxt = alu_res;
    end else if (ctrl_i.div_step) begin
      quot_nxt = {quot_r[TEMP_W-2:0], ~alu_borrow};
      if (!alu_borrow) begin
        acc_nxt = alu_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    quot_r <= quot_nxt;
  end

  assign fill_o = fill_r;
  assign quot_o = quot_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(AVG_DEPTH))
    else $error("fill count beyond ring depth");

  a_wp_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != FILL_W'(AVG_DEPTH)) |-> (FILL_W'(wp_r) == fill_r))
    else $error("write pointer out of step with fill count");

endmodule

[hw/rtl/thg_seq.sv]
// Sequencer: steps the shared unit through accumulation and divide steps.
// Uses thg_pkg; drives thg_dp through a thg_ctrl_t bundle.
module thg_seq import thg_pkg::*; #(
  parameter int  AVG_DEPTH = AVG_DEPTH_DEF,
  localparam int FILL_W    = $clog2(AVG_DEPTH + 1),
  localparam int IDX_W     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start_i,
  input  logic              sample_i,
  input  logic              out_free_i,
  input  logic [FILL_W-1:0] fill_i,
  output logic              idle_o,
  output logic              finish_o,
  output thg_ctrl_t         ctrl_o,
  output logic [IDX_W-1:0]  idx_o,
  output logic [BIT_W-1:0]  bit_o
);

  seq_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      bit_r   <= bit_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    bit_nxt   = bit_r;
    ctrl_o    = '0;
    idle_o    = 1'b0;
    finish_o  = 1'b0;
    case (state_r)
      S_IDLE: begin
        idle_o = 1'b1;
        if (start_i) begin
          if (sample_i) begin
            ctrl_o.ring_wr = 1'b1;
            ctrl_o.acc_clr = 1'b1;
            idx_nxt        = '0;
            state_nxt      = S_ACCUM;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_ACCUM: begin
        ctrl_o.acc_add = 1'b1;
        if (FILL_W'(idx_r) == fill_i - FILL_W'(1)) begin
          idx_nxt   = '0;
          bit_nxt   = DIV_TOP_BIT;
          state_nxt = S_DIV;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DIV: begin
        ctrl_o.div_step = 1'b1;
        if (bit_r == '0) begin
          state_nxt = S_FINISH;
        end else begin
          bit_nxt = bit_r - 1'b1;
        end
      end
      S_FINISH: begin
        if (out_free_i) begin
          finish_o  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign idx_o = idx_r;
  assign bit_o = bit_r;

  a_idx_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACCUM) |-> (FILL_W'(idx_r) < fill_i))
    else $error("accumulation index past filled entries");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && bit_r == '0) |=> (state_r == S_FINISH))
    else $error("divide did not end after last step");

endmodule

[hw/rtl/thermal_hysteresis_governor_top.sv]
// Thermal hysteresis governor: one item in, one result item out.
// A sample item makes one add per filled ring entry and one restoring divide step per
// quotient bit on a shared unit; force and rejected items skip both. in_tready is high
// only while the sequencer is idle; a finished result waits in the output register
// until taken.
// Reset (rst_n low at a clock edge) restores thresholds, state, average and trips.
module thermal_hysteresis_governor_top import thg_pkg::*; #(
  parameter int AVG_DEPTH = AVG_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [15:0]        in_tdata,    // temperature[7:0], requested_state[15:8]
  input  logic [0:0]         in_tuser,    // action[0]
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [31:0]        out_tdata,   // perf_state[1:0], average_temp[9:2],
                                          // trips[25:10], zero[31:26]
  output logic [1:0]         out_tuser,   // rejected[0], critical[1]
  input  logic               cfg_wr_en,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]   cfg_wr_data
);

  localparam int FILL_W = $clog2(AVG_DEPTH + 1);
  localparam int IDX_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;

  logic [TEMP_W-1:0]  rise_r, fall_r, crit_r, maxt_r;
  logic [STATE_W-1:0] perf_r, perf_nxt;
  logic [TEMP_W-1:0]  avg_r, avg_nxt;
  logic [TRIP_W-1:0]  trip_r, trip_nxt;
  item_kind_t         kind_r;
  logic [TEMP_W-1:0]  req_r;
  logic               out_valid_r;
  logic [31:0]        out_data_r;
  logic [1:0]         out_user_r;
  logic               rej_nxt, crit_nxt;

  logic               accept, sample_ok, finish, idle;
  logic [TEMP_W-1:0]  in_temp;
  thg_ctrl_t          ctrl;
  logic [FILL_W-1:0]  fill;
  logic [TEMP_W-1:0]  quot;
  logic [IDX_W-1:0]   idx;
  logic [BIT_W-1:0]   bitpos;

  assign in_temp   = in_tdata[7:0];
  assign accept    = in_tvalid && in_tready;
  assign sample_ok = !in_tuser[0] && (in_temp <= maxt_r);
  assign in_tready = idle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_r <= RISE_RST;
      fall_r <= FALL_RST;
      crit_r <= CRIT_RST;
      maxt_r <= MAXT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_RISE: rise_r <= cfg_wr_data;
        CFG_FALL: fall_r <= cfg_wr_data;
        CFG_CRIT: crit_r <= cfg_wr_data;
        CFG_MAXT: maxt_r <= cfg_wr_data;
        default: begin
        end
      endcase
    end
  end

  thg_seq #(.AVG_DEPTH(AVG_DEPTH)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (accept),
    .sample_i   (sample_ok),
    .out_free_i (!out_valid_r || out_tready),
    .fill_i     (fill),
    .idle_o     (idle),
    .finish_o   (finish),
    .ctrl_o     (ctrl),
    .idx_o      (idx),
    .bit_o      (bitpos)
  );

  thg_dp #(.AVG_DEPTH(AVG_DEPTH)) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl_i (ctrl),
    .idx_i  (idx),
    .bit_i  (bitpos),
    .temp_i (in_temp),
    .fill_o (fill),
    .quot_o (quot)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_tdata[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_FORCE;
    end else if (accept) begin
      if (in_tuser[0]) begin
        kind_r <= KIND_FORCE;
      end else if (in_temp > maxt_r) begin
        kind_r <= KIND_REJECT;
      end else begin
        kind_r <= KIND_SAMPLE;
      end
    end
  end

  always_comb begin
    perf_nxt = perf_r;
    avg_nxt  = avg_r;
    trip_nxt = trip_r;
    rej_nxt  = 1'b0;
    crit_nxt = 1'b0;
    case (kind_r)
      KIND_FORCE: begin
        if (req_r[TEMP_W-1]) begin
          perf_nxt = '0;
        end else if (req_r[TEMP_W-2:0] > (TEMP_W-1)'(NUM_STATES - 1)) begin
          perf_nxt = STATE_MAX;
        end else begin
          perf_nxt = req_r[STATE_W-1:0];
        end
      end
      KIND_REJECT: begin
        rej_nxt = 1'b1;
      end
      KIND_SAMPLE: begin
        avg_nxt = quot;
        if (quot >= crit_r) begin
          crit_nxt = 1'b1;
          perf_nxt = STATE_MAX;
          if (trip_r != TRIP_MAX) begin
            trip_nxt = trip_r + 1'b1;
          end
        end else if (quot >= rise_r) begin
          if (perf_r != STATE_MAX) begin
            perf_nxt = perf_r + 1'b1;
          end
        end else if (quot <= fall_r) begin
          if (perf_r != '0) begin
            perf_nxt = perf_r - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perf_r      <= '0;
      avg_r       <= AVG_RST;
      trip_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (finish) begin
        perf_r      <= perf_nxt;
        avg_r       <= avg_nxt;
        trip_r      <= trip_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data_r <= {6'd0, trip_nxt, avg_nxt, perf_nxt};
      out_user_r <= {crit_nxt, rej_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_crit_slowest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_user_r[1]) |-> (out_data_r[STATE_W-1:0] == STATE_MAX))
    else $error("critical result without slowest state");

  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && kind_r == KIND_REJECT) |=>
      (perf_r == $past(perf_r) && avg_r == $past(avg_r) && trip_r == $past(trip_r)))
    else $error("rejected item changed governor state");

  a_trip_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (trip_r >= $past(trip_r)))
    else $error("trip counter decreased");

endmodule

[tb/thermal_hysteresis_governor_top_test.sv]
// Testbench for thermal_hysteresis_governor_top: drives sample and force items under
// several threshold settings and checks every result item against a predictor of its own.
// Depends on thg_pkg and the top-level RTL only.
`timescale 1ns / 1ps

import thg_pkg::*;

typedef struct {
  logic [STATE_W-1:0] perf;
  logic [TEMP_W-1:0]  avg;
  logic [TRIP_W-1:0]  trips;
  logic               rejected;
  logic               critical;
} gov_report_t;

class governor_tracker;
  logic [TEMP_W-1:0]  rise_lvl, fall_lvl, crit_lvl, max_temp;
  logic [TEMP_W-1:0]  ring [AVG_DEPTH_DEF];
  int                 wr_ptr;
  int                 fill;
  logic [STATE_W-1:0] perf;
  logic [TEMP_W-1:0]  avg;
  logic [TRIP_W-1:0]  trips;
  gov_report_t        pending_reports[$];
  int                 errors;

  function new();
    rise_lvl = RISE_RST;
    fall_lvl = FALL_RST;
    crit_lvl = CRIT_RST;
    max_temp = MAXT_RST;
    foreach (ring[i]) ring[i] = AVG_RST;
    wr_ptr = 0;
    fill = 0;
    perf = '0;
    avg = AVG_RST;
    trips = '0;
    errors = 0;
  endfunction

  function void set_reg(logic [CFG_A_W-1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      CFG_RISE: rise_lvl = val;
      CFG_FALL: fall_lvl = val;
      CFG_CRIT: crit_lvl = val;
      CFG_MAXT: max_temp = val;
      default: ;
    endcase
  endfunction

  function void take_item(logic force_it, logic [TEMP_W-1:0] temp, logic signed [7:0] req);
    gov_report_t rep;
    int sum;
    rep.rejected = 1'b0;
    rep.critical = 1'b0;
    if (force_it) begin
      if (req < 0) begin
        perf = '0;
      end else if (req > NUM_STATES - 1) begin
        perf = STATE_MAX;
      end else begin
        perf = req[STATE_W-1:0];
      end
    end else if (temp > max_temp) begin
      rep.rejected = 1'b1;
    end else begin
      ring[wr_ptr] = temp;
      wr_ptr = (wr_ptr + 1) % AVG_DEPTH_DEF;
      if (fill < AVG_DEPTH_DEF) fill++;
      sum = 0;
      for (int i = 0; i < fill; i++) sum += ring[i];
      avg = TEMP_W'(sum / fill);
      if (avg >= crit_lvl) begin
        if (trips != TRIP_MAX) trips++;
        perf = STATE_MAX;
        rep.critical = 1'b1;
      end else if (avg >= rise_lvl) begin
        if (perf != STATE_MAX) perf++;
      end else if (avg <= fall_lvl) begin
        if (perf != 0) perf--;
      end
    end
    rep.perf = perf;
    rep.avg = avg;
    rep.trips = trips;
    pending_reports.push_back(rep);
  endfunction

  function void compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function void check_report(gov_report_t got);
    gov_report_t want;
    if (pending_reports.size() == 0) begin
      $error("result item arrived with none outstanding");
      errors++;
      return;
    end
    want = pending_reports.pop_front();
    compare_field("perf_state", want.perf, got.perf);
    compare_field("average_temp", want.avg, got.avg);
    compare_field("trips", want.trips, got.trips);
    compare_field("rejected", want.rejected, got.rejected);
    compare_field("critical", want.critical, got.critical);
  endfunction
endclass

module thermal_hysteresis_governor_top_test;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_FORCE  = 1'b1;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [15:0]        in_tdata = '0;
  logic [0:0]         in_tuser = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [31:0]        out_tdata;
  logic [1:0]         out_tuser;
  logic               cfg_wr_en = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]   cfg_wr_data = '0;

  logic               steady = 1'b0;
  governor_tracker    tracker = new();

  thermal_hysteresis_governor_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 27);
  end

  always @(posedge clk) begin
    gov_report_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.perf = out_tdata[1:0];
      got.avg = out_tdata[9:2];
      got.trips = out_tdata[25:10];
      got.rejected = out_tuser[0];
      got.critical = out_tuser[1];
      tracker.check_report(got);
    end
  end

  task automatic send_item(input logic action, input logic [7:0] temp, input logic [7:0] req);
    while (!steady && $urandom_range(0, 99) < 27) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= action;
    in_tdata <= {req, temp};
    do @(posedge clk); while (!in_tready);
    tracker.take_item(action == ACT_FORCE, temp, req);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (tracker.pending_reports.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wr_data <= val;
    @(negedge clk);
    tracker.set_reg(idx, val);
  endtask

  task automatic apply_settings(input logic [7:0] rise, input logic [7:0] fall,
                                input logic [7:0] crit, input logic [7:0] maxt);
    write_reg(CFG_RISE, rise);
    write_reg(CFG_FALL, fall);
    write_reg(CFG_CRIT, crit);
    write_reg(CFG_MAXT, maxt);
    cfg_wr_en <= 1'b0;
  endtask

  // About 45 percent of the samples land close to a threshold so the state walks through its hysteresis band.
  function automatic logic [7:0] pick_temp();
    int r;
    int t;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      case ($urandom_range(0, 3))
        0: t = tracker.rise_lvl;
        1: t = tracker.fall_lvl;
        2: t = tracker.crit_lvl;
        default: t = tracker.max_temp;
      endcase
      t = t + int'($urandom_range(0, 8)) - 4;
      if (t < 0) t = 0;
      if (t > 255) t = 255;
    end else if (r < 75) begin
      t = $urandom_range(0, 255);
    end else begin
      t = $urandom_range(0, tracker.max_temp);
    end
    return t[7:0];
  endfunction

  task automatic random_item();
    logic [7:0] req;
    req = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 5));
    if ($urandom_range(0, 99) < 12) begin
      send_item(ACT_FORCE, 8'($urandom_range(0, 255)), req);
    end else begin
      send_item(ACT_SAMPLE, pick_temp(), req);
    end
  endtask

  initial begin
    logic [7:0] s [4];
    int hold_at;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    apply_settings(RISE_RST, FALL_RST, CRIT_RST, MAXT_RST);

    // Forced states across the signed range, including clamping at both ends.
    send_item(ACT_FORCE, 8'd0, 8'h80);
    send_item(ACT_FORCE, 8'd255, 8'h7F);
    send_item(ACT_FORCE, 8'd0, 8'hFF);
    send_item(ACT_FORCE, 8'd0, 8'd4);
    send_item(ACT_FORCE, 8'd0, 8'd0);
    // A step faster from the fastest state does nothing.
    send_item(ACT_SAMPLE, 8'd0, 8'd0);
    send_item(ACT_FORCE, 8'd0, 8'd2);
    send_item(ACT_SAMPLE, 8'd0, 8'd0);
    // Rejection just above the limit and at full scale, acceptance at the limit.
    send_item(ACT_SAMPLE, 8'd126, 8'd0);
    send_item(ACT_SAMPLE, 8'd255, 8'hFF);
    send_item(ACT_SAMPLE, 8'd125, 8'd0);
    // Fill and wrap the ring until the average crosses rise and then critical.
    repeat (5) send_item(ACT_SAMPLE, 8'd125, 8'd0);
    // A critical average at the slowest state keeps the state there.
    send_item(ACT_FORCE, 8'd0, 8'd3);
    send_item(ACT_SAMPLE, 8'd80, 8'd0);
    // Cool down through the band and below the fall level.
    repeat (4) send_item(ACT_SAMPLE, 8'd70, 8'd0);
    repeat (4) send_item(ACT_SAMPLE, 8'd10, 8'd0);
    send_item(ACT_FORCE, 8'd0, 8'd1);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: s = '{8'd75, 8'd60, 8'd95, 8'd255};
        1: s = '{8'd255, 8'd255, 8'd255, 8'd255};
        2: s = '{8'd0, 8'd0, 8'd0, 8'd0};
        3: s = '{8'd40, 8'd200, 8'd150, 8'd220};
        4: begin
          foreach (s[i]) s[i] = 8'($urandom_range(0, 255));
        end
        default: s = '{8'd90, 8'd30, 8'd120, 8'd200};
      endcase
      wait_drained();
      steady <= (ph == 3);
      apply_settings(s[0], s[1], s[2], s[3]);
      hold_at = $urandom_range(10, 70);
      for (int n = 0; n < 88; n++) begin
        if (n == hold_at) wait_drained();
        random_item();
      end
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (tracker.errors == 0 && tracker.pending_reports.size() == 0) begin
      $display("thermal_hysteresis_governor_top: match");
    end else begin
      $display("thermal_hysteresis_governor_top: mismatch");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("thermal_hysteresis_governor_top: mismatch");
    $finish;
  end

endmodule
